>>> rtl/core/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and constants for the sorted insert list.
// ----------------------------------------------------------------------------
package sil_pkg;

	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 16;
	localparam int CNT_BITS   = $clog2(DEPTH + 1);
	localparam int SUM_BITS   = 20;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef struct packed {
		op_t                           op;
		logic signed [VALUE_BITS-1:0]  value;
	} req_word_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0]  out_value;
		logic                          is_last;
		logic [CNT_BITS-1:0]           count;
		logic signed [SUM_BITS-1:0]    total_sum;
		logic                          dropped;
		logic                          is_empty;
	} rsp_word_t;

	// broadcast to every cell
	typedef struct packed {
		logic                          insert;
		logic                          rotate;
		logic signed [VALUE_BITS-1:0]  value;
	} cell_ctl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic                          valid;
		logic signed [VALUE_BITS-1:0]  value;
		logic                          ge;
	} cell_link_t;

endpackage

>>> rtl/core/sorted_insert_list.sv
// ----------------------------------------------------------------------------
// sorted_insert_list
// Ascending store of signed values built as a chain of compare/shift cells.
// ----------------------------------------------------------------------------
// On an insert word every cell compares its entry with the new value at once
// and the cells at and after the insertion point shift right by one. A readout
// word gives one response per stored value (a single one when the store is
// empty): the occupied cells rotate one place per cycle while the output
// register can load and cell 0 feeds it, so after the last value the chain
// is back in its original order. A new request word is taken only after the
// previous word's results have all been loaded into the output register.
module sorted_insert_list
	import sil_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t                     state_q;
	logic [CNT_BITS-1:0]        count_q;
	logic [CNT_BITS-1:0]        rem_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic                       rsp_valid_q;
	rsp_word_t                  rsp_q;

	cell_ctl_t                  ctl;
	cell_link_t                 link [DEPTH];
	logic                       can_load;
	logic                       accept;
	logic                       full;
	logic signed [SUM_BITS-1:0] sum_next;

	assign can_load  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) && can_load);
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_BITS'(DEPTH));
	assign sum_next  = sum_q + {{(SUM_BITS-VALUE_BITS){req.value[VALUE_BITS-1]}}, req.value};
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		ctl.value  = req.value;
		ctl.insert = accept && (req.op == OP_INSERT) && !full;
		ctl.rotate = (accept && (req.op == OP_READ) && (count_q != '0)) ||
			((state_q == ST_READ) && can_load);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_link_t                   prev;
		logic                         next_valid;
		logic signed [VALUE_BITS-1:0] next_value;

		if (i == 0) begin : g_first
			assign prev = '{valid: 1'b1, value: '0, ge: 1'b0};
		end else begin : g_mid
			assign prev = link[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_valid = 1'b0;
			assign next_value = '0;
		end else begin : g_inner
			assign next_valid = link[i+1].valid;
			assign next_value = link[i+1].value;
		end

		sil_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.head_value (link[0].value),
			.prev       (prev),
			.next_valid (next_valid),
			.next_value (next_value),
			.link       (link[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			sum_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rsp_valid_q     <= 1'b1;
						rsp_q.is_last   <= 1'b1;
						rsp_q.dropped   <= 1'b0;
						rsp_q.is_empty  <= 1'b0;
						rsp_q.count     <= count_q;
						rsp_q.total_sum <= sum_q;
						unique case (req.op)
							OP_INSERT: begin
								rsp_q.out_value <= req.value;
								if (full) begin
									rsp_q.dropped <= 1'b1;
								end else begin
									count_q         <= count_q + 1'b1;
									sum_q           <= sum_next;
									rsp_q.count     <= count_q + 1'b1;
									rsp_q.total_sum <= sum_next;
								end
							end
							OP_READ: begin
								if (count_q == '0) begin
									rsp_q.out_value <= '0;
									rsp_q.is_empty  <= 1'b1;
								end else begin
									rsp_q.out_value <= link[0].value;
									rsp_q.is_last   <= (count_q == CNT_BITS'(1));
									rem_q           <= count_q - 1'b1;
									if (count_q != CNT_BITS'(1)) begin
										state_q <= ST_READ;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					if (can_load) begin
						rsp_valid_q     <= 1'b1;
						rsp_q.out_value <= link[0].value;
						rsp_q.is_last   <= (rem_q == CNT_BITS'(1));
						rsp_q.count     <= count_q;
						rsp_q.total_sum <= sum_q;
						rsp_q.dropped   <= 1'b0;
						rsp_q.is_empty  <= 1'b0;
						rem_q           <= rem_q - 1'b1;
						if (rem_q == CNT_BITS'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/sil_cell.sv
// ----------------------------------------------------------------------------
// sil_cell
// One slot of the sorted chain: compares against the broadcast value and
// takes the new value, its left neighbor's entry, or (on readout) rotates.
// ----------------------------------------------------------------------------
module sil_cell
	import sil_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctl_t                    ctl,
	input  logic signed [VALUE_BITS-1:0] head_value,
	input  cell_link_t                   prev,
	input  logic                         next_valid,
	input  logic signed [VALUE_BITS-1:0] next_value,
	output cell_link_t                   link
);

	logic                         valid_q;
	logic signed [VALUE_BITS-1:0] value_q;
	logic                         ge;

	assign ge         = !valid_q || (value_q >= ctl.value);
	assign link.valid = valid_q;
	assign link.value = value_q;
	assign link.ge    = ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert && ge) begin
			valid_q <= prev.ge ? prev.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && ge) begin
			value_q <= prev.ge ? prev.value : ctl.value;
		end else if (ctl.rotate && valid_q) begin
			// last occupied cell wraps around to the head
			value_q <= next_valid ? next_value : head_value;
		end
	end

endmodule
